>>> sv/udpchk_pkg.sv
// Shared types and constants for the UDP over IPv6 receive checker.
// Used by the front, queue, back and checker modules and the top level.
// No dependencies.
package udpchk_pkg;

  localparam int MAX_PAYLOAD = 2048;
  localparam int COUNT_WIDTH = 16;
  localparam int LEN_W       = 16;
  localparam int CMP_W       = (COUNT_WIDTH > LEN_W) ? COUNT_WIDTH : LEN_W;

  // depth kept at a power of two so the pointers wrap on their own
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // header byte offsets
  localparam logic [COUNT_WIDTH-1:0] OFF_SPORT_HI = COUNT_WIDTH'(0);
  localparam logic [COUNT_WIDTH-1:0] OFF_SPORT_LO = COUNT_WIDTH'(1);
  localparam logic [COUNT_WIDTH-1:0] OFF_DPORT_HI = COUNT_WIDTH'(2);
  localparam logic [COUNT_WIDTH-1:0] OFF_DPORT_LO = COUNT_WIDTH'(3);
  localparam logic [COUNT_WIDTH-1:0] OFF_LEN_HI   = COUNT_WIDTH'(4);
  localparam logic [COUNT_WIDTH-1:0] OFF_LEN_LO   = COUNT_WIDTH'(5);
  localparam logic [COUNT_WIDTH-1:0] OFF_CSUM_HI  = COUNT_WIDTH'(6);
  localparam logic [COUNT_WIDTH-1:0] OFF_CSUM_LO  = COUNT_WIDTH'(7);

  localparam logic [LEN_W-1:0] UDP_HDR_LEN    = LEN_W'(8);
  localparam logic [LEN_W-1:0] NEXT_HDR_UDP   = LEN_W'(17);

  localparam logic [2:0] VERDICT_ACCEPT    = 3'd0;
  localparam logic [2:0] VERDICT_SHORT     = 3'd1;
  localparam logic [2:0] VERDICT_LEN_SMALL = 3'd2;
  localparam logic [2:0] VERDICT_LEN_BIG   = 3'd3;
  localparam logic [2:0] VERDICT_TOO_BIG   = 3'd4;
  localparam logic [2:0] VERDICT_ZERO_CSUM = 3'd5;
  localparam logic [2:0] VERDICT_BAD_CSUM  = 3'd6;

  typedef struct packed {
    logic [63:0] src_addr_hi;
    logic [63:0] src_addr_lo;
    logic [63:0] dst_addr_hi;
    logic [63:0] dst_addr_lo;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
  } udpchk_in_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [11:0] payload_length;
    logic [15:0] residue;
  } udpchk_out_t;

  // summary of one finished segment, front to back
  typedef struct packed {
    logic [3:0][17:0]        addr_part;
    logic [15:0]             data_sum;
    logic [7:0]              pend;
    logic [LEN_W-1:0]        len;
    logic [15:0]             csum;
    logic [15:0]             sport;
    logic [15:0]             dport;
    logic [COUNT_WIDTH-1:0]  count;
  } udpchk_seg_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } udpchk_qstat_t;

endpackage

>>> sv/udpchk_front.sv
// Front end: takes one segment byte per request, captures header fields
// and keeps the running data sum and address partial sums. Uses udpchk_pkg.
module udpchk_front import udpchk_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  udpchk_in_t    in_data,
  input  udpchk_qstat_t q_stat,
  output logic          push,
  output udpchk_seg_t   push_data
);

  function automatic logic [17:0] word_sum64(input logic [63:0] v);
    logic [17:0] s;
    s = 18'(v[15:0]) + 18'(v[31:16]) + 18'(v[47:32]) + 18'(v[63:48]);
    return s;
  endfunction

  logic [COUNT_WIDTH-1:0] byte_count_r, byte_count_nxt;
  logic [15:0]            acc_r, acc_nxt;
  logic [7:0]             pend_r, pend_nxt;
  logic [LEN_W-1:0]       len_r, len_nxt;
  logic [15:0]            csum_r, csum_nxt;
  logic [15:0]            sport_r, sport_nxt;
  logic [15:0]            dport_r, dport_nxt;
  logic [3:0][17:0]       addr_part_r, addr_part_nxt;

  logic                   accept;
  logic [COUNT_WIDTH-1:0] idx;
  logic [7:0]             b;
  logic                   sum_en;
  logic [16:0]            sum17;
  logic [15:0]            acc_base;
  logic [7:0]             pend_base;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign b        = in_data.data_byte;
  assign idx      = in_data.first_byte ? '0 : byte_count_r;

  always_comb begin
    // a first byte restarts every field
    sport_nxt = in_data.first_byte ? 16'h0 : sport_r;
    dport_nxt = in_data.first_byte ? 16'h0 : dport_r;
    len_nxt   = in_data.first_byte ? '0 : len_r;
    csum_nxt  = in_data.first_byte ? 16'h0 : csum_r;
    acc_base  = in_data.first_byte ? 16'h0 : acc_r;
    pend_base = in_data.first_byte ? 8'h0 : pend_r;
    if (in_data.first_byte) begin
      addr_part_nxt[0] = word_sum64(in_data.src_addr_hi);
      addr_part_nxt[1] = word_sum64(in_data.src_addr_lo);
      addr_part_nxt[2] = word_sum64(in_data.dst_addr_hi);
      addr_part_nxt[3] = word_sum64(in_data.dst_addr_lo);
    end else begin
      addr_part_nxt = addr_part_r;
    end

    case (idx)
      OFF_SPORT_HI: sport_nxt[15:8] = b;
      OFF_SPORT_LO: sport_nxt[7:0]  = b;
      OFF_DPORT_HI: dport_nxt[15:8] = b;
      OFF_DPORT_LO: dport_nxt[7:0]  = b;
      OFF_LEN_HI:   len_nxt[15:8]   = b;
      OFF_LEN_LO:   len_nxt[7:0]    = b;
      OFF_CSUM_HI:  csum_nxt[15:8]  = b;
      OFF_CSUM_LO:  csum_nxt[7:0]   = b;
      default: ;
    endcase

    // ports and length always summed; checksum and rest only within length
    sum_en = (idx != COUNT_MAX) &&
             ((idx < OFF_CSUM_HI) || (CMP_W'(idx) < CMP_W'(len_nxt)));

    sum17    = {1'b0, acc_base} + {1'b0, pend_base, b};
    pend_nxt = pend_base;
    acc_nxt  = acc_base;
    if (sum_en) begin
      if (!idx[0]) begin
        pend_nxt = b;
      end else begin
        acc_nxt = sum17[15:0] + 16'(sum17[16]);
      end
    end

    byte_count_nxt = (idx != COUNT_MAX) ? idx + COUNT_WIDTH'(1) : idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      acc_r        <= '0;
      pend_r       <= '0;
      len_r        <= '0;
      csum_r       <= '0;
      sport_r      <= '0;
      dport_r      <= '0;
      addr_part_r  <= '0;
    end else if (accept) begin
      byte_count_r <= byte_count_nxt;
      acc_r        <= acc_nxt;
      pend_r       <= pend_nxt;
      len_r        <= len_nxt;
      csum_r       <= csum_nxt;
      sport_r      <= sport_nxt;
      dport_r      <= dport_nxt;
      addr_part_r  <= addr_part_nxt;
    end
  end

  assign push = accept && in_data.last_byte;

  always_comb begin
    push_data.addr_part = addr_part_nxt;
    push_data.data_sum  = acc_nxt;
    push_data.pend      = pend_nxt;
    push_data.len       = len_nxt;
    push_data.csum      = csum_nxt;
    push_data.sport     = sport_nxt;
    push_data.dport     = dport_nxt;
    push_data.count     = byte_count_nxt;
  end

endmodule

>>> sv/udpchk_queue.sv
// Short queue of finished-segment summaries between front and back.
// Uses udpchk_pkg.
module udpchk_queue import udpchk_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  udpchk_seg_t   push_data,
  input  logic          pop,
  output udpchk_seg_t   pop_data,
  output udpchk_qstat_t q_stat
);

  udpchk_seg_t       entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + (QPTR_W+1)'(1);
    if (pop && !push) count_nxt = count_r - (QPTR_W+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_data;
  end

  assign pop_data        = entry_r[rd_ptr_r];
  assign q_stat.full     = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_stat.nonempty = (count_r != '0);

endmodule

>>> sv/udpchk_back.sv
// Back end: length checks and partial sums, then the final fold, residue
// check and the output register. Uses udpchk_pkg.
module udpchk_back import udpchk_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  udpchk_qstat_t q_stat,
  input  udpchk_seg_t   seg,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output udpchk_out_t   out_data
);

  logic        s1_valid_r;
  logic [19:0] addr_sum_r, addr_sum_nxt;
  logic [17:0] misc_sum_r, misc_sum_nxt;
  logic [2:0]  pre_r, pre_nxt;
  logic [15:0] sport_r, dport_r;
  logic [11:0] pl_r;

  logic        out_valid_r;
  udpchk_out_t out_data_r, out_data_nxt;

  logic        out_free, s1_adv;
  logic [LEN_W-1:0] len_less_hdr;
  logic [20:0] total;
  logic [16:0] fold1;
  logic [15:0] folded, residue;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = !s1_valid_r || out_free;
  assign pop      = q_stat.nonempty && s1_adv;

  // stage 1: structural checks and two partial sums
  always_comb begin
    len_less_hdr = seg.len - UDP_HDR_LEN;
    addr_sum_nxt = 20'(seg.addr_part[0]) + 20'(seg.addr_part[1]) +
                   20'(seg.addr_part[2]) + 20'(seg.addr_part[3]);
    // odd length: the held byte is padded as a high byte
    misc_sum_nxt = 18'(seg.data_sum) + 18'(seg.len) + 18'(NEXT_HDR_UDP) +
                   (seg.len[0] ? 18'({seg.pend, 8'h00}) : 18'h0);
    if (seg.count < COUNT_WIDTH'(8)) begin
      pre_nxt = VERDICT_SHORT;
    end else if (seg.len < UDP_HDR_LEN) begin
      pre_nxt = VERDICT_LEN_SMALL;
    end else if (CMP_W'(seg.len) > CMP_W'(seg.count)) begin
      pre_nxt = VERDICT_LEN_BIG;
    end else if ({1'b0, len_less_hdr} > 17'(MAX_PAYLOAD)) begin
      pre_nxt = VERDICT_TOO_BIG;
    end else if (seg.csum == 16'h0) begin
      pre_nxt = VERDICT_ZERO_CSUM;
    end else begin
      pre_nxt = VERDICT_ACCEPT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      addr_sum_r <= addr_sum_nxt;
      misc_sum_r <= misc_sum_nxt;
      pre_r      <= pre_nxt;
      sport_r    <= seg.sport;
      dport_r    <= seg.dport;
      pl_r       <= len_less_hdr[11:0];
    end
  end

  // stage 2: end-around fold; total is never zero so the fold lands in 1..ffff
  always_comb begin
    total   = 21'(addr_sum_r) + 21'(misc_sum_r);
    fold1   = {1'b0, total[15:0]} + 17'(total[20:16]);
    folded  = fold1[15:0] + 16'(fold1[16]);
    residue = ~folded;

    out_data_nxt.source_port      = sport_r;
    out_data_nxt.destination_port = dport_r;
    out_data_nxt.residue          = residue;
    out_data_nxt.payload_length   = 12'h0;
    if (pre_r != VERDICT_ACCEPT) begin
      out_data_nxt.verdict = pre_r;
    end else if (residue != 16'h0) begin
      out_data_nxt.verdict = VERDICT_BAD_CSUM;
    end else begin
      out_data_nxt.verdict        = VERDICT_ACCEPT;
      out_data_nxt.payload_length = pl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid_r) out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> sv/udp_ipv6_rx_checker_unit.sv
// Top level of the UDP over IPv6 receive checksum checker.
// Instantiates udpchk_front, udpchk_queue and udpchk_back; uses udpchk_pkg.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+--------------
//   in_     | in        | in_valid / in_stall   | udpchk_in_t
//   out_    | out       | out_valid / out_stall | udpchk_out_t
//
// A segment byte is taken every cycle that in_stall is low; in_stall
// only rises while the two-entry summary queue is full behind a stalled
// output. The result of a segment passes through the queue slot, the check
// stage and the output register after its last byte is taken.
// Reset is synchronous and clears counters, valids and segment state.
// A stalled output holds; the front keeps taking bytes until the queue fills.
module udp_ipv6_rx_checker_unit import udpchk_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  udpchk_in_t  in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output udpchk_out_t out_data
);

  udpchk_qstat_t q_stat;
  udpchk_seg_t   push_data, pop_data;
  logic          push, pop;

  udpchk_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  udpchk_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  udpchk_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .seg       (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> sv/udpchk_checker.sv
// Port-level checks for udp_ipv6_rx_checker_unit, attached by bind.
// Uses udpchk_pkg.
module udpchk_checker import udpchk_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input udpchk_out_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_accept_res: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.verdict == VERDICT_ACCEPT) |-> out_data.residue == 16'h0)
    else $error("accepted segment with nonzero residue");

  a_bad_res: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.verdict == VERDICT_BAD_CSUM) |-> out_data.residue != 16'h0)
    else $error("bad checksum verdict with zero residue");

  a_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.verdict != VERDICT_ACCEPT) |-> out_data.payload_length == 12'h0)
    else $error("payload length on rejected segment");

endmodule

bind udp_ipv6_rx_checker_unit udpchk_checker u_udpchk_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> verif/udpchk_verdict_checker.sv
// Watches both channels of udp_ipv6_rx_checker_unit, predicts each segment
// verdict from the accepted bytes and compares it with the returned result.
// Depends on udpchk_pkg for the request and result types and constants.
module udpchk_verdict_checker import udpchk_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  udpchk_in_t  in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  udpchk_out_t out_data,
  output int          fail_count,
  output int          pending_cnt,
  output int          verdicts_checked
);

  localparam int REPORT_LIMIT = 40;

  // predicted segment state
  logic [31:0]            run_sum;
  logic [COUNT_WIDTH-1:0] byte_cnt;
  logic [15:0]            len_fld;
  logic [15:0]            sport;
  logic [15:0]            dport;
  logic [15:0]            csum_fld;
  logic [7:0]             pend_hi;

  udpchk_out_t pending_verdicts[$];
  int          mismatches;
  int          checked;

  function automatic logic [31:0] fold_carry(input logic [31:0] x);
    logic [31:0] t;
    t = {16'h0, x[15:0]} + {16'h0, x[31:16]};
    t = {16'h0, t[15:0]} + {16'h0, t[31:16]};
    return t;
  endfunction

  function automatic logic [31:0] addr_word_sum(input logic [63:0] v);
    return 32'(v[15:0]) + 32'(v[31:16]) + 32'(v[47:32]) + 32'(v[63:48]);
  endfunction

  task automatic clear_segment();
    run_sum  = '0;
    byte_cnt = '0;
    len_fld  = '0;
    sport    = '0;
    dport    = '0;
    csum_fld = '0;
    pend_hi  = '0;
  endtask

  task automatic absorb_byte(input udpchk_in_t req);
    logic [COUNT_WIDTH-1:0] idx;
    logic [7:0]             b;
    logic [31:0]            s;
    logic [15:0]            resid;
    logic [2:0]             verdict;
    logic [11:0]            plen;
    udpchk_out_t            exp_res;
    b = req.data_byte;
    if (req.first_byte) begin
      clear_segment();
      run_sum = fold_carry(addr_word_sum(req.src_addr_hi) + addr_word_sum(req.src_addr_lo) +
                           addr_word_sum(req.dst_addr_hi) + addr_word_sum(req.dst_addr_lo));
    end
    idx = byte_cnt;
    case (idx)
      OFF_SPORT_HI: sport[15:8]    = b;
      OFF_SPORT_LO: sport[7:0]     = b;
      OFF_DPORT_HI: dport[15:8]    = b;
      OFF_DPORT_LO: dport[7:0]     = b;
      OFF_LEN_HI:   len_fld[15:8]  = b;
      OFF_LEN_LO:   len_fld[7:0]   = b;
      OFF_CSUM_HI:  csum_fld[15:8] = b;
      OFF_CSUM_LO:  csum_fld[7:0]  = b;
      default: ;
    endcase
    // header words up to the checksum are always summed, the rest only within length
    if (idx < COUNT_MAX && (idx < OFF_CSUM_HI || CMP_W'(idx) < CMP_W'(len_fld))) begin
      if (!idx[0]) pend_hi = b;
      else run_sum = fold_carry(run_sum + {16'h0, pend_hi, b});
    end
    if (byte_cnt < COUNT_MAX) byte_cnt = byte_cnt + COUNT_WIDTH'(1);
    if (!req.last_byte) return;

    s = run_sum + 32'(len_fld) + 32'(NEXT_HDR_UDP);
    if (len_fld[0]) s = s + {16'h0, pend_hi, 8'h00};
    s = fold_carry(s);
    resid = ~s[15:0];
    plen = '0;
    if (CMP_W'(byte_cnt) < CMP_W'(UDP_HDR_LEN)) verdict = VERDICT_SHORT;
    else if (len_fld < UDP_HDR_LEN) verdict = VERDICT_LEN_SMALL;
    else if (CMP_W'(len_fld) > CMP_W'(byte_cnt)) verdict = VERDICT_LEN_BIG;
    else if (int'(len_fld) - 8 > MAX_PAYLOAD) verdict = VERDICT_TOO_BIG;
    else if (csum_fld == 16'h0) verdict = VERDICT_ZERO_CSUM;
    else if (resid != 16'h0) verdict = VERDICT_BAD_CSUM;
    else begin
      verdict = VERDICT_ACCEPT;
      plen = 12'(len_fld - UDP_HDR_LEN);
    end
    exp_res.verdict          = verdict;
    exp_res.source_port      = sport;
    exp_res.destination_port = dport;
    exp_res.payload_length   = plen;
    exp_res.residue          = resid;
    pending_verdicts.push_back(exp_res);
  endtask

  task automatic check_field(input string fname, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      if (mismatches < REPORT_LIMIT)
        $error("%s: expected %0d, got %0d", fname, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    udpchk_out_t exp_res;
    if (!rst_n) begin
      clear_segment();
      pending_verdicts.delete();
    end else begin
      if (in_valid && !in_stall) absorb_byte(in_data);
      if (out_valid && !out_stall) begin
        if (pending_verdicts.size() == 0) begin
          if (mismatches < REPORT_LIMIT)
            $error("unexpected result: verdict %0d, source_port %0d",
                   out_data.verdict, out_data.source_port);
          mismatches++;
        end else begin
          exp_res = pending_verdicts.pop_front();
          check_field("verdict", 32'(exp_res.verdict), 32'(out_data.verdict));
          check_field("source_port", 32'(exp_res.source_port), 32'(out_data.source_port));
          check_field("destination_port", 32'(exp_res.destination_port),
                      32'(out_data.destination_port));
          check_field("payload_length", 32'(exp_res.payload_length),
                      32'(out_data.payload_length));
          check_field("residue", 32'(exp_res.residue), 32'(out_data.residue));
          checked++;
        end
      end
    end
    fail_count       <= mismatches;
    pending_cnt      <= pending_verdicts.size();
    verdicts_checked <= checked;
  end

endmodule

>>> verif/testbench.sv
// Stimulus and verdict for udp_ipv6_rx_checker_unit: directed and random UDP
// segments fed byte by byte with random idling on both channels.
// Depends on udpchk_pkg and udpchk_verdict_checker.
module testbench import udpchk_pkg::*;;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 20;
  localparam int RANDOM_BYTES = 950;
  localparam int RANDOM_SEGS  = 30;

  typedef enum int {CSUM_GOOD, CSUM_BAD, CSUM_ZERO} csum_mode_e;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  udpchk_in_t  in_data   = '0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  udpchk_out_t out_data;

  int fail_count;
  int pending_cnt;
  int verdicts_checked;
  int cycle_cnt = 0;

  // sender state
  bit          valid_up   = 1'b0;
  bit          gap_on     = 1'b0;
  logic        hold_req   = 1'b0;
  int          bytes_sent = 0;
  int          segs_sent  = 0;
  logic [63:0] addr_sh, addr_sl, addr_dh, addr_dl;
  logic [7:0]  seg_bytes[$];

  udp_ipv6_rx_checker_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  udpchk_verdict_checker i_verdict_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data         (out_data),
    .fail_count       (fail_count),
    .pending_cnt      (pending_cnt),
    .verdicts_checked (verdicts_checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side: free runs, short stalls, a few long ones, and one long hold on request
  initial begin : rx_stall
    int   r;
    int   dur;
    logic stall_val;
    bit   hold_used;
    hold_used = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !hold_used) begin
        hold_used = 1'b1;
        stall_val = 1'b1;
        dur = HOLD_CYCLES;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          stall_val = 1'b0;
          dur = $urandom_range(1, 60);
        end else if (r < 90) begin
          stall_val = 1'b1;
          dur = $urandom_range(1, 3);
        end else begin
          stall_val = 1'b1;
          dur = $urandom_range(10, 40);
        end
      end
      out_stall <= stall_val;
      repeat (dur) @(posedge clk);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [31:0] fold_sum(input logic [31:0] x);
    logic [31:0] t;
    t = {16'h0, x[15:0]} + {16'h0, x[31:16]};
    t = {16'h0, t[15:0]} + {16'h0, t[31:16]};
    return t;
  endfunction

  function automatic logic [31:0] word_sum(input logic [63:0] v);
    return 32'(v[15:0]) + 32'(v[31:16]) + 32'(v[47:32]) + 32'(v[63:48]);
  endfunction

  task automatic set_addrs(input logic [63:0] sh, sl, dh, dl);
    addr_sh = sh;
    addr_sl = sl;
    addr_dh = dh;
    addr_dl = dl;
  endtask

  task automatic drop_valid();
    if (valid_up) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
    end
  endtask

  task automatic send_item(input udpchk_in_t req);
    int gap;
    int r;
    gap = 0;
    if (gap_on) begin
      r = $urandom_range(0, 99);
      if (r >= 95) gap = $urandom_range(8, 40);
      else if (r >= 75) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      drop_valid();
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    valid_up = 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // addresses ride with the first byte; on later bytes they carry noise
  task automatic send_seg(input bit with_first, input bit with_last);
    udpchk_in_t req;
    bit         head;
    for (int i = 0; i < seg_bytes.size(); i++) begin
      head = with_first && (i == 0);
      req.src_addr_hi = head ? addr_sh : rand64();
      req.src_addr_lo = head ? addr_sl : rand64();
      req.dst_addr_hi = head ? addr_dh : rand64();
      req.dst_addr_lo = head ? addr_dl : rand64();
      req.data_byte   = seg_bytes[i];
      req.first_byte  = head;
      req.last_byte   = with_last && (i == seg_bytes.size() - 1);
      send_item(req);
    end
    if (with_last) segs_sent++;
  endtask

  task automatic fill_random(input int n);
    seg_bytes.delete();
    repeat (n) seg_bytes.push_back(8'($urandom));
  endtask

  // lf < 0 gives the natural length; fill < 0 gives random payload
  task automatic make_seg(input int pay_n, input int lf, input int extra,
                          input csum_mode_e mode, input logic [15:0] sp,
                          input logic [15:0] dp, input int fill);
    logic [15:0] lfw;
    logic [15:0] ck;
    logic [31:0] s;
    logic [15:0] w;
    int          n;
    lfw = (lf < 0) ? 16'(8 + pay_n) : 16'(lf);
    seg_bytes.delete();
    seg_bytes.push_back(sp[15:8]);
    seg_bytes.push_back(sp[7:0]);
    seg_bytes.push_back(dp[15:8]);
    seg_bytes.push_back(dp[7:0]);
    seg_bytes.push_back(lfw[15:8]);
    seg_bytes.push_back(lfw[7:0]);
    seg_bytes.push_back(8'h00);
    seg_bytes.push_back(8'h00);
    repeat (pay_n) seg_bytes.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
    repeat (extra) seg_bytes.push_back(8'($urandom));
    n = (int'(lfw) < seg_bytes.size()) ? int'(lfw) : seg_bytes.size();
    s = fold_sum(word_sum(addr_sh) + word_sum(addr_sl) + word_sum(addr_dh) +
                 word_sum(addr_dl) + 32'(lfw) + 32'(NEXT_HDR_UDP));
    for (int i = 0; i < n; i += 2) begin
      w = {seg_bytes[i], (i + 1 < n) ? seg_bytes[i + 1] : 8'h00};
      s = fold_sum(s + 32'(w));
    end
    ck = ~s[15:0];
    if (ck == 16'h0) ck = 16'hffff;
    case (mode)
      CSUM_BAD:  ck = ck ^ 16'($urandom_range(1, 65535));
      CSUM_ZERO: ck = 16'h0;
      default: ;
    endcase
    seg_bytes[6] = ck[15:8];
    seg_bytes[7] = ck[7:0];
  endtask

  task automatic wait_drained();
    drop_valid();
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
  endtask

  initial begin
    int          kind;
    int          pay;
    int          b0;
    int          s0;
    logic [15:0] sp;
    logic [15:0] dp;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // bytes straight out of reset with no first marker: zero addresses
    set_addrs('0, '0, '0, '0);
    make_seg(4, -1, 0, CSUM_GOOD, 16'h1234, 16'h0035, -1);
    send_seg(1'b0, 1'b1);
    // more bytes after a last byte extend that segment past its length
    seg_bytes = '{8'h11, 8'h22, 8'h33};
    send_seg(1'b0, 1'b1);
    // one-byte segment, then a seven-byte one
    set_addrs(rand64(), rand64(), rand64(), rand64());
    seg_bytes = '{8'hff};
    send_seg(1'b1, 1'b1);
    fill_random(7);
    send_seg(1'b1, 1'b1);
    // field extremes
    set_addrs('1, '1, '1, '1);
    make_seg(0, -1, 0, CSUM_GOOD, 16'hffff, 16'hffff, 8'hff);
    send_seg(1'b1, 1'b1);
    set_addrs('0, '0, '0, '0);
    make_seg(6, -1, 0, CSUM_GOOD, 16'h0000, 16'h0000, 8'h00);
    send_seg(1'b1, 1'b1);
    set_addrs(rand64(), rand64(), rand64(), rand64());
    make_seg(8, -1, 0, CSUM_GOOD, 16'hffff, 16'h0000, 8'hff);
    send_seg(1'b1, 1'b1);
    // odd length: last byte padded as a high byte
    make_seg(3, -1, 0, CSUM_GOOD, 16'($urandom), 16'($urandom), -1);
    send_seg(1'b1, 1'b1);
    // length field under the header size
    make_seg(0, 5, 0, CSUM_GOOD, 16'($urandom), 16'($urandom), -1);
    send_seg(1'b1, 1'b1);
    make_seg(2, 0, 0, CSUM_GOOD, 16'($urandom), 16'($urandom), -1);
    send_seg(1'b1, 1'b1);
    // length field beyond the bytes received
    make_seg(10, 21, 0, CSUM_GOOD, 16'($urandom), 16'($urandom), -1);
    send_seg(1'b1, 1'b1);
    make_seg(2, 16'hffff, 0, CSUM_GOOD, 16'($urandom), 16'($urandom), -1);
    send_seg(1'b1, 1'b1);
    // trailing bytes past the length field are counted, not summed
    make_seg(4, -1, 5, CSUM_GOOD, 16'($urandom), 16'($urandom), -1);
    send_seg(1'b1, 1'b1);
    make_seg(8, -1, 0, CSUM_ZERO, 16'($urandom), 16'($urandom), -1);
    send_seg(1'b1, 1'b1);
    make_seg(8, -1, 0, CSUM_BAD, 16'($urandom), 16'($urandom), -1);
    send_seg(1'b1, 1'b1);
    wait_drained();

    // long result hold while short segments keep coming, so the input backs up
    hold_req <= 1'b1;
    repeat (20) begin
      set_addrs(rand64(), rand64(), rand64(), rand64());
      make_seg($urandom_range(0, 4), -1, 0, CSUM_GOOD, 16'($urandom), 16'($urandom), -1);
      send_seg(1'b1, 1'b1);
    end
    wait_drained();

    b0 = bytes_sent;
    s0 = segs_sent;
    while (bytes_sent - b0 < RANDOM_BYTES || segs_sent - s0 < RANDOM_SEGS) begin
      gap_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 19) == 0) begin
        if ($urandom_range(0, 1) == 0) set_addrs('1, '1, '1, '1);
        else set_addrs('0, '0, '0, '0);
      end else begin
        set_addrs(rand64(), rand64(), rand64(), rand64());
      end
      sp = 16'($urandom);
      dp = 16'($urandom);
      pay = $urandom_range(0, 40);
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        make_seg(pay, -1, 0, CSUM_GOOD, sp, dp, -1);
        send_seg(1'b1, 1'b1);
      end else if (kind < 68) begin
        make_seg(pay, -1, 0, CSUM_BAD, sp, dp, -1);
        send_seg(1'b1, 1'b1);
      end else if (kind < 74) begin
        make_seg(pay, -1, 0, CSUM_ZERO, sp, dp, -1);
        send_seg(1'b1, 1'b1);
      end else if (kind < 79) begin
        make_seg(pay, $urandom_range(0, 7), 0, CSUM_GOOD, sp, dp, -1);
        send_seg(1'b1, 1'b1);
      end else if (kind < 84) begin
        make_seg(pay, 8 + pay + $urandom_range(1, 20), 0, CSUM_GOOD, sp, dp, -1);
        send_seg(1'b1, 1'b1);
      end else if (kind < 89) begin
        make_seg(pay, -1, $urandom_range(1, 9), CSUM_GOOD, sp, dp, -1);
        send_seg(1'b1, 1'b1);
      end else if (kind < 94) begin
        fill_random($urandom_range(1, 7));
        send_seg(1'b1, 1'b1);
      end else if (kind < 97) begin
        // tail bytes onto whatever segment came before
        fill_random($urandom_range(1, 6));
        send_seg(1'b0, 1'b1);
      end else begin
        fill_random($urandom_range(1, 10));
        send_seg(1'($urandom_range(0, 1)), 1'b0);
      end
      if ($urandom_range(0, 39) == 0) wait_drained();
    end
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d bytes in %0d segments, with short, odd, padded and extended ones;",
             bytes_sent, segs_sent);
    $display("%0d results compared under input gaps, output stalls and one long hold.",
             verdicts_checked);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
